// ----- rtl/ctt_pkg.sv -----
`default_nettype none

package ctt_pkg;

    // Default sizing, handed to the top level as parameter defaults
    localparam int OFFSET_BITS_DEF   = 32;
    localparam int KEYWORD_SLOTS_DEF = 4;
    localparam int KEYWORD_CHARS_DEF = 8;
    localparam int COUNT_BITS_DEF    = 16;

    // Configuration port
    localparam int KEY_REGS       = 4;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 64;

    // Token queue, power-of-two depth so pointers wrap naturally
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    // Token field widths
    localparam int KIND_BITS   = 4;
    localparam int START_BITS  = 32;
    localparam int LENGTH_BITS = 16;
    localparam int LINE_BITS   = 16;
    localparam int COLUMN_BITS = 16;
    localparam int QUAL_BITS   = 3;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_STRUCT_OPEN  = 4'd0,
        KIND_STRUCT_CLOSE = 4'd1,
        KIND_ARRAY_OPEN   = 4'd2,
        KIND_ARRAY_CLOSE  = 4'd3,
        KIND_BLOCK_OPEN   = 4'd4,
        KIND_BLOCK_CLOSE  = 4'd5,
        KIND_IDENTIFIER   = 4'd6,
        KIND_KEYWORD      = 4'd7,
        KIND_NUMBER       = 4'd8,
        KIND_STRING       = 4'd9
    } token_kind_t;

    typedef enum logic [QUAL_BITS-1:0] {
        QUAL_NONE        = 3'd0,
        QUAL_FILE_TEXT   = 3'd1,
        QUAL_FILE_BINARY = 3'd2,
        QUAL_CONST_DECL  = 3'd3,
        QUAL_CONST_REF   = 3'd4
    } qual_t;

    // Characters
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_AT       = 8'h40;
    localparam logic [7:0] CH_AMP      = 8'h26;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_DIGIT_LO = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI = 8'h39;
    localparam logic [7:0] CH_UPPER_LO = 8'h41;
    localparam logic [7:0] CH_UPPER_HI = 8'h5A;
    localparam logic [7:0] CH_LOWER_LO = 8'h61;
    localparam logic [7:0] CH_LOWER_HI = 8'h7A;

    typedef struct packed {
        token_kind_t              kind;
        logic [START_BITS-1:0]    start;
        logic [LENGTH_BITS-1:0]   length;
        logic [LINE_BITS-1:0]     line;
        logic [COLUMN_BITS-1:0]   column;
        qual_t                    qualifier;
        logic                     last;
    } token_t;

    // Tokens caused by one request: zero, one or two
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } scan_out_t;

endpackage

`default_nettype wire

// ----- rtl/config_text_tokenizer_unit.sv -----
`default_nettype none

// Tokens: a token enters the token queue at the clock edge that takes the byte that ends it.
// Throughput: one byte per cycle unless stalled; the four-entry queue absorbs the second
// token of a closing bracket, and text_stall rises only while that queue holds three or more.
// Reset: rst_n is asynchronous, active low; it clears the scanner to start mode, line and
// column to one, offsets to zero, empties the token queue and zeroes all keyword registers.

module config_text_tokenizer_unit #(
    parameter int OFFSET_BITS   = ctt_pkg::OFFSET_BITS_DEF,
    parameter int KEYWORD_SLOTS = ctt_pkg::KEYWORD_SLOTS_DEF,
    parameter int KEYWORD_CHARS = ctt_pkg::KEYWORD_CHARS_DEF,
    parameter int COUNT_BITS    = ctt_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // Keyword configuration
    input  wire logic                                cfg_wr_en,
    input  wire logic [ctt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [ctt_pkg::CFG_DATA_BITS-1:0]   cfg_data,

    // Text byte request
    input  wire logic                                text_valid,
    output logic                                     text_stall,
    input  wire logic [7:0]                          text_byte,

    // Token request
    output logic                                     token_valid,
    input  wire logic                                token_stall,
    output logic [ctt_pkg::KIND_BITS-1:0]            token_kind,
    output logic [ctt_pkg::START_BITS-1:0]           lexeme_start,
    output logic [ctt_pkg::LENGTH_BITS-1:0]          lexeme_length,
    output logic [ctt_pkg::LINE_BITS-1:0]            line_number,
    output logic [ctt_pkg::COLUMN_BITS-1:0]          column_number,
    output logic [ctt_pkg::QUAL_BITS-1:0]            qualifier,
    output logic                                     last_of_run
);

    logic                         text_accept;
    logic                         token_pop;
    logic [8*KEYWORD_CHARS-1:0]   word_prefix;
    logic                         word_overlong;
    logic                         keyword_hit;
    logic                         queue_nearly_full;
    ctt_pkg::scan_out_t           scan_result;
    ctt_pkg::token_t              head;

    // Take a byte only when the queue can hold both tokens it might cause
    assign text_stall  = queue_nearly_full;
    assign text_accept = text_valid && !text_stall;
    assign token_pop   = token_valid && !token_stall;

    // Keyword registers and the compare against the word collected so far
    ctt_keyword_bank #(
        .KEYWORD_SLOTS (KEYWORD_SLOTS),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_keyword_bank (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .word_prefix   (word_prefix),
        .word_overlong (word_overlong),
        .keyword_hit   (keyword_hit)
    );

    // Mode machine, position counters and token assembly; all state advances
    // only on an accepted byte
    ctt_scan #(
        .OFFSET_BITS   (OFFSET_BITS),
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (text_accept),
        .text_byte     (text_byte),
        .keyword_hit   (keyword_hit),
        .word_prefix   (word_prefix),
        .word_overlong (word_overlong),
        .result        (scan_result)
    );

    // Token queue: holds finished tokens until the consumer takes them
    ctt_token_queue u_token_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (scan_result),
        .pop         (token_pop),
        .head        (head),
        .not_empty   (token_valid),
        .nearly_full (queue_nearly_full)
    );

    assign token_kind    = head.kind;
    assign lexeme_start  = head.start;
    assign lexeme_length = head.length;
    assign line_number   = head.line;
    assign column_number = head.column;
    assign qualifier     = head.qualifier;
    assign last_of_run   = head.last;

endmodule

`default_nettype wire

// ----- rtl/ctt_keyword_bank.sv -----
`default_nettype none

module ctt_keyword_bank #(
    parameter int KEYWORD_SLOTS = ctt_pkg::KEYWORD_SLOTS_DEF,
    parameter int KEYWORD_CHARS = ctt_pkg::KEYWORD_CHARS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [ctt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [ctt_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic [8*KEYWORD_CHARS-1:0]         word_prefix,
    input  wire logic                               word_overlong,
    output logic                                    keyword_hit
);

    localparam int WORD_BITS  = 8 * KEYWORD_CHARS;
    localparam int USED_SLOTS = (KEYWORD_SLOTS < ctt_pkg::KEY_REGS) ?
                                KEYWORD_SLOTS : ctt_pkg::KEY_REGS;

    logic [WORD_BITS-1:0] key_reg [USED_SLOTS];

    // Writes to an index past the used slots are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < USED_SLOTS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            for (int i = 0; i < USED_SLOTS; i++)
            begin
                if (cfg_index == ctt_pkg::CFG_INDEX_BITS'(i))
                begin
                    key_reg[i] <= cfg_data[WORD_BITS-1:0];
                end
            end
        end
    end

    always_comb
    begin
        keyword_hit = 1'b0;
        for (int i = 0; i < USED_SLOTS; i++)
        begin
            if ((key_reg[i] != '0) && (key_reg[i] == word_prefix))
            begin
                keyword_hit = 1'b1;
            end
        end
        if (word_overlong)
        begin
            keyword_hit = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ctt_scan.sv -----
`default_nettype none

module ctt_scan #(
    parameter int OFFSET_BITS   = ctt_pkg::OFFSET_BITS_DEF,
    parameter int KEYWORD_CHARS = ctt_pkg::KEYWORD_CHARS_DEF,
    parameter int COUNT_BITS    = ctt_pkg::COUNT_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [7:0]                 text_byte,
    input  wire logic                       keyword_hit,
    output logic [8*KEYWORD_CHARS-1:0]      word_prefix,
    output logic                            word_overlong,
    output ctt_pkg::scan_out_t              result
);

    localparam int WORD_BITS = 8 * KEYWORD_CHARS;
    localparam int OW = (OFFSET_BITS > ctt_pkg::START_BITS) ? OFFSET_BITS : ctt_pkg::START_BITS;
    localparam int CW = (COUNT_BITS > ctt_pkg::LENGTH_BITS) ? COUNT_BITS : ctt_pkg::LENGTH_BITS;

    typedef enum logic [2:0] {
        MODE_START,
        MODE_NUMBER,
        MODE_WORD,
        MODE_STRING,
        MODE_COMMENT
    } mode_t;

    mode_t                    mode_reg,     mode_next;
    logic [OFFSET_BITS-1:0]   pos_reg,      pos_next;
    logic [OFFSET_BITS-1:0]   begin_reg,    begin_next;
    logic [COUNT_BITS-1:0]    size_reg,     size_next;
    logic [COUNT_BITS-1:0]    line_reg,     line_next;
    logic [COUNT_BITS-1:0]    col_reg,      col_next;
    ctt_pkg::qual_t           qual_reg,     qual_next;
    logic [WORD_BITS-1:0]     prefix_reg,   prefix_next;
    logic                     overlong_reg, overlong_next;

    function automatic logic [ctt_pkg::START_BITS-1:0] clamp_offset(
        input logic [OFFSET_BITS-1:0] v
    );
        logic [OW-1:0] e;
        e = OW'(v);
        if (e > OW'({ctt_pkg::START_BITS{1'b1}}))
        begin
            return '1;
        end
        return e[ctt_pkg::START_BITS-1:0];
    endfunction

    function automatic logic [ctt_pkg::LENGTH_BITS-1:0] clamp_count(
        input logic [COUNT_BITS-1:0] v
    );
        logic [CW-1:0] e;
        e = CW'(v);
        if (e > CW'({ctt_pkg::LENGTH_BITS{1'b1}}))
        begin
            return '1;
        end
        return e[ctt_pkg::LENGTH_BITS-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] count_inc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] offset_inc(input logic [OFFSET_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    logic                                 is_digit, is_alpha, is_number, is_word;
    logic                                 close_hit;
    ctt_pkg::token_kind_t                 close_kind;
    logic [ctt_pkg::LINE_BITS-1:0]        line_out;
    logic [ctt_pkg::COLUMN_BITS-1:0]      col_out;
    ctt_pkg::token_t                      tok_main, tok_close;
    logic                                 emit_main;
    logic                                 emit_close;

    always_comb
    begin
        mode_next     = mode_reg;
        pos_next      = pos_reg;
        begin_next    = begin_reg;
        size_next     = size_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        qual_next     = qual_reg;
        prefix_next   = prefix_reg;
        overlong_next = overlong_reg;
        emit_main     = 1'b0;
        emit_close    = 1'b0;

        is_digit  = text_byte inside {[ctt_pkg::CH_DIGIT_LO:ctt_pkg::CH_DIGIT_HI]};
        is_alpha  = (text_byte inside {[ctt_pkg::CH_UPPER_LO:ctt_pkg::CH_UPPER_HI]}) ||
                    (text_byte inside {[ctt_pkg::CH_LOWER_LO:ctt_pkg::CH_LOWER_HI]});
        is_number = is_digit || (text_byte == ctt_pkg::CH_DOT);
        is_word   = is_alpha || is_number || (text_byte == ctt_pkg::CH_UNDER);

        if (text_byte == ctt_pkg::CH_NEWLINE)
        begin
            col_next  = COUNT_BITS'(1);
            line_next = count_inc(line_reg);
        end
        else
        begin
            col_next = count_inc(col_reg);
        end
        line_out = clamp_count(line_next);
        col_out  = clamp_count(col_next);

        close_hit  = 1'b1;
        close_kind = ctt_pkg::KIND_ARRAY_CLOSE;
        case (text_byte)
            ctt_pkg::CH_RBRACKET: close_kind = ctt_pkg::KIND_ARRAY_CLOSE;
            ctt_pkg::CH_RBRACE:   close_kind = ctt_pkg::KIND_BLOCK_CLOSE;
            ctt_pkg::CH_RPAREN:   close_kind = ctt_pkg::KIND_STRUCT_CLOSE;
            default:              close_hit  = 1'b0;
        endcase

        tok_main           = '0;
        tok_main.line      = line_out;
        tok_main.column    = col_out;
        tok_main.qualifier = qual_reg;
        tok_main.start     = clamp_offset(begin_reg);
        tok_main.length    = clamp_count(size_reg);

        tok_close           = '0;
        tok_close.kind      = close_kind;
        tok_close.start     = clamp_offset(pos_reg);
        tok_close.length    = ctt_pkg::LENGTH_BITS'(1);
        tok_close.line      = line_out;
        tok_close.column    = col_out;
        tok_close.qualifier = ctt_pkg::QUAL_NONE;
        tok_close.last      = 1'b1;

        case (mode_reg)
            MODE_START:
            begin
                if (is_number)
                begin
                    begin_next = pos_reg;
                    size_next  = COUNT_BITS'(1);
                    mode_next  = MODE_NUMBER;
                end
                else if (is_alpha || (text_byte == ctt_pkg::CH_UNDER))
                begin
                    begin_next    = pos_reg;
                    size_next     = COUNT_BITS'(1);
                    prefix_next   = WORD_BITS'(text_byte);
                    overlong_next = 1'b0;
                    mode_next     = MODE_WORD;
                end
                else
                begin
                    // Single-character tokens carry no qualifier and leave it pending
                    tok_main.start     = clamp_offset(pos_reg);
                    tok_main.length    = ctt_pkg::LENGTH_BITS'(1);
                    tok_main.qualifier = ctt_pkg::QUAL_NONE;
                    case (text_byte)
                        ctt_pkg::CH_QUOTE:
                        begin
                            begin_next = offset_inc(pos_reg);
                            size_next  = '0;
                            mode_next  = MODE_STRING;
                        end
                        ctt_pkg::CH_HASH:     mode_next = MODE_COMMENT;
                        ctt_pkg::CH_LPAREN:
                        begin
                            emit_main     = 1'b1;
                            tok_main.kind = ctt_pkg::KIND_STRUCT_OPEN;
                        end
                        ctt_pkg::CH_LBRACKET:
                        begin
                            emit_main     = 1'b1;
                            tok_main.kind = ctt_pkg::KIND_ARRAY_OPEN;
                        end
                        ctt_pkg::CH_RBRACKET:
                        begin
                            emit_main     = 1'b1;
                            tok_main.kind = ctt_pkg::KIND_ARRAY_CLOSE;
                        end
                        ctt_pkg::CH_LBRACE:
                        begin
                            emit_main     = 1'b1;
                            tok_main.kind = ctt_pkg::KIND_BLOCK_OPEN;
                        end
                        ctt_pkg::CH_RBRACE:
                        begin
                            emit_main     = 1'b1;
                            tok_main.kind = ctt_pkg::KIND_BLOCK_CLOSE;
                        end
                        ctt_pkg::CH_AT:       qual_next = ctt_pkg::QUAL_FILE_TEXT;
                        ctt_pkg::CH_AMP:      qual_next = ctt_pkg::QUAL_FILE_BINARY;
                        ctt_pkg::CH_COLON:    qual_next = ctt_pkg::QUAL_CONST_DECL;
                        ctt_pkg::CH_DOLLAR:   qual_next = ctt_pkg::QUAL_CONST_REF;
                        default:              mode_next = MODE_START;
                    endcase
                end
            end
            MODE_COMMENT:
            begin
                if ((text_byte == ctt_pkg::CH_NEWLINE) || (text_byte == ctt_pkg::CH_HASH))
                begin
                    mode_next = MODE_START;
                end
            end
            MODE_NUMBER:
            begin
                if (is_number)
                begin
                    size_next = count_inc(size_reg);
                end
                else
                begin
                    emit_main     = 1'b1;
                    emit_close    = close_hit;
                    tok_main.kind = ctt_pkg::KIND_NUMBER;
                    qual_next     = ctt_pkg::QUAL_NONE;
                    size_next     = '0;
                    mode_next     = MODE_START;
                end
            end
            MODE_WORD:
            begin
                if (is_word)
                begin
                    for (int j = 0; j < KEYWORD_CHARS; j++)
                    begin
                        if (size_reg == COUNT_BITS'(j))
                        begin
                            prefix_next[8*j +: 8] = text_byte;
                        end
                    end
                    if (size_reg >= COUNT_BITS'(KEYWORD_CHARS))
                    begin
                        overlong_next = 1'b1;
                    end
                    size_next = count_inc(size_reg);
                end
                else
                begin
                    emit_main     = 1'b1;
                    emit_close    = close_hit;
                    tok_main.kind = keyword_hit ? ctt_pkg::KIND_KEYWORD :
                                                  ctt_pkg::KIND_IDENTIFIER;
                    qual_next     = ctt_pkg::QUAL_NONE;
                    size_next     = '0;
                    mode_next     = MODE_START;
                end
            end
            MODE_STRING:
            begin
                if (text_byte == ctt_pkg::CH_QUOTE)
                begin
                    emit_main     = 1'b1;
                    tok_main.kind = ctt_pkg::KIND_STRING;
                    qual_next     = ctt_pkg::QUAL_NONE;
                    size_next     = '0;
                    mode_next     = MODE_START;
                end
                else
                begin
                    size_next = count_inc(size_reg);
                end
            end
            default:
            begin
                mode_next = MODE_START;
            end
        endcase

        pos_next      = offset_inc(pos_reg);
        tok_main.last = !emit_close;

        result        = '0;
        result.first  = tok_main;
        result.second = tok_close;
        if (accept)
        begin
            result.count = {emit_main && emit_close, emit_main && !emit_close};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_START;
            pos_reg      <= '0;
            begin_reg    <= '0;
            size_reg     <= '0;
            line_reg     <= COUNT_BITS'(1);
            col_reg      <= COUNT_BITS'(1);
            qual_reg     <= ctt_pkg::QUAL_NONE;
            prefix_reg   <= '0;
            overlong_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            pos_reg      <= pos_next;
            begin_reg    <= begin_next;
            size_reg     <= size_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            qual_reg     <= qual_next;
            prefix_reg   <= prefix_next;
            overlong_reg <= overlong_next;
        end
    end

    assign word_prefix   = prefix_reg;
    assign word_overlong = overlong_reg;

endmodule

`default_nettype wire

// ----- rtl/ctt_token_queue.sv -----
`default_nettype none

module ctt_token_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ctt_pkg::scan_out_t  push,
    input  wire logic                pop,
    output ctt_pkg::token_t          head,
    output logic                     not_empty,
    output logic                     nearly_full
);

    localparam int DEPTH = ctt_pkg::QUEUE_DEPTH;
    localparam int PB    = ctt_pkg::QUEUE_PTR_BITS;
    localparam int CB    = ctt_pkg::QUEUE_CNT_BITS;

    ctt_pkg::token_t mem [DEPTH];

    logic [PB-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PB-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CB-1:0] count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PB'(push.count);
        rd_ptr_next = rd_ptr_reg + PB'(pop);
        count_next  = count_reg + CB'(push.count) - CB'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + PB'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head        = mem[rd_ptr_reg];
    assign not_empty   = (count_reg != '0);
    // Keep room for two tokens, the most one request can cause
    assign nearly_full = (count_reg > CB'(DEPTH - 2));

endmodule

`default_nettype wire

// ----- tb/sv/ctt_token_checker.sv -----
`timescale 1ns / 100ps

module ctt_token_checker
    import ctt_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                      text_valid,
    input  wire logic                      text_stall,
    input  wire logic [7:0]                text_byte,
    input  wire logic                      token_valid,
    input  wire logic                      token_stall,
    input  wire logic [KIND_BITS-1:0]      token_kind,
    input  wire logic [START_BITS-1:0]     lexeme_start,
    input  wire logic [LENGTH_BITS-1:0]    lexeme_length,
    input  wire logic [LINE_BITS-1:0]      line_number,
    input  wire logic [COLUMN_BITS-1:0]    column_number,
    input  wire logic [QUAL_BITS-1:0]      qualifier,
    input  wire logic                      last_of_run,
    output int                             mismatch_count,
    output int                             tokens_due
);

    localparam int              KEY_CHARS  = KEYWORD_CHARS_DEF;
    localparam int              KEY_SLOTS  = KEYWORD_SLOTS_DEF < KEY_REGS ? KEYWORD_SLOTS_DEF
                                                                          : KEY_REGS;
    localparam longint unsigned OFFSET_MAX = ~64'd0 >> (64 - OFFSET_BITS_DEF);
    localparam longint unsigned COUNT_MAX  = ~64'd0 >> (64 - COUNT_BITS_DEF);
    localparam logic [63:0]     KEY_MASK   = ~64'd0 >> (64 - 8 * KEY_CHARS);

    typedef enum logic [2:0] {
        SCAN_START,
        SCAN_NUMBER,
        SCAN_WORD,
        SCAN_STRING,
        SCAN_COMMENT
    } scan_mode_t;

    scan_mode_t      mode;
    longint unsigned pos;
    longint unsigned lex_begin;
    longint unsigned lex_size;
    longint unsigned line_cnt;
    longint unsigned col_cnt;
    qual_t           pend_qual;
    logic [63:0]     word_bytes;
    logic            word_too_long;
    logic [63:0]     key_reg [KEY_REGS];
    token_t          due_tokens [$];
    int              run_count;
    int              errors;

    function automatic longint unsigned bump(longint unsigned v, longint unsigned maxv);
        return (v >= maxv) ? maxv : v + 1;
    endfunction

    function automatic longint unsigned clamp_to(longint unsigned v, int bits);
        longint unsigned maxv;
        maxv = ~64'd0 >> (64 - bits);
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_DIGIT_LO && c <= CH_DIGIT_HI;
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return (c >= CH_UPPER_LO && c <= CH_UPPER_HI) || (c >= CH_LOWER_LO && c <= CH_LOWER_HI);
    endfunction

    // Overlong words never match, and an all-zero register matches nothing
    function automatic logic keyword_hit();
        logic [63:0] key;
        if (word_too_long)
            return 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            key = key_reg[i] & KEY_MASK;
            if (key != '0 && key == word_bytes)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic string describe(token_t t);
        return $sformatf("kind %0d start %0d len %0d line %0d col %0d qual %0d last %0b",
                         t.kind, t.start, t.length, t.line, t.column, t.qualifier, t.last);
    endfunction

    task automatic emit(input token_kind_t kind, input longint unsigned start,
                        input longint unsigned len, input qual_t qual);
        token_t tok;
        tok.kind      = kind;
        tok.start     = START_BITS'(clamp_to(start, START_BITS));
        tok.length    = LENGTH_BITS'(clamp_to(len, LENGTH_BITS));
        tok.line      = LINE_BITS'(clamp_to(line_cnt, LINE_BITS));
        tok.column    = COLUMN_BITS'(clamp_to(col_cnt, COLUMN_BITS));
        tok.qualifier = qual;
        tok.last      = 1'b0;
        due_tokens.push_back(tok);
        run_count++;
    endtask

    task automatic add_word_char(input logic [7:0] c);
        if (lex_size < KEY_CHARS)
            word_bytes[8 * lex_size +: 8] = c;
        else
            word_too_long = 1'b1;
        lex_size = bump(lex_size, COUNT_MAX);
    endtask

    // The ending byte is consumed; a closing bracket adds its own token
    task automatic close_lexeme(input token_kind_t kind, input logic [7:0] c);
        emit(kind, lex_begin, lex_size, pend_qual);
        pend_qual = QUAL_NONE;
        lex_size  = 0;
        mode      = SCAN_START;
        case (c)
            CH_RBRACKET: emit(KIND_ARRAY_CLOSE, pos, 1, QUAL_NONE);
            CH_RBRACE:   emit(KIND_BLOCK_CLOSE, pos, 1, QUAL_NONE);
            CH_RPAREN:   emit(KIND_STRUCT_CLOSE, pos, 1, QUAL_NONE);
            default: ;
        endcase
    endtask

    task automatic scan_byte(input logic [7:0] c);
        token_t tok;
        run_count = 0;
        if (c == CH_NEWLINE) begin
            col_cnt  = 1;
            line_cnt = bump(line_cnt, COUNT_MAX);
        end
        else begin
            col_cnt = bump(col_cnt, COUNT_MAX);
        end

        case (mode)
            SCAN_START:
            begin
                if (is_digit(c) || c == CH_DOT) begin
                    lex_begin = pos;
                    lex_size  = 1;
                    mode      = SCAN_NUMBER;
                end
                else if (is_letter(c) || c == CH_UNDER) begin
                    lex_begin     = pos;
                    lex_size      = 0;
                    word_bytes    = '0;
                    word_too_long = 1'b0;
                    add_word_char(c);
                    mode = SCAN_WORD;
                end
                else if (c == CH_QUOTE) begin
                    lex_begin = bump(pos, OFFSET_MAX);
                    lex_size  = 0;
                    mode      = SCAN_STRING;
                end
                else if (c == CH_HASH) begin
                    mode = SCAN_COMMENT;
                end
                else begin
                    // a lone ')' is dropped here
                    case (c)
                        CH_LPAREN:   emit(KIND_STRUCT_OPEN, pos, 1, QUAL_NONE);
                        CH_LBRACKET: emit(KIND_ARRAY_OPEN, pos, 1, QUAL_NONE);
                        CH_RBRACKET: emit(KIND_ARRAY_CLOSE, pos, 1, QUAL_NONE);
                        CH_LBRACE:   emit(KIND_BLOCK_OPEN, pos, 1, QUAL_NONE);
                        CH_RBRACE:   emit(KIND_BLOCK_CLOSE, pos, 1, QUAL_NONE);
                        CH_AT:       pend_qual = QUAL_FILE_TEXT;
                        CH_AMP:      pend_qual = QUAL_FILE_BINARY;
                        CH_COLON:    pend_qual = QUAL_CONST_DECL;
                        CH_DOLLAR:   pend_qual = QUAL_CONST_REF;
                        default: ;
                    endcase
                end
            end
            SCAN_COMMENT:
            begin
                if (c == CH_NEWLINE || c == CH_HASH)
                    mode = SCAN_START;
            end
            SCAN_NUMBER:
            begin
                if (is_digit(c) || c == CH_DOT)
                    lex_size = bump(lex_size, COUNT_MAX);
                else
                    close_lexeme(KIND_NUMBER, c);
            end
            SCAN_WORD:
            begin
                if (is_letter(c) || is_digit(c) || c == CH_UNDER || c == CH_DOT)
                    add_word_char(c);
                else
                    close_lexeme(keyword_hit() ? KIND_KEYWORD : KIND_IDENTIFIER, c);
            end
            SCAN_STRING:
            begin
                if (c == CH_QUOTE) begin
                    emit(KIND_STRING, lex_begin, lex_size, pend_qual);
                    pend_qual = QUAL_NONE;
                    lex_size  = 0;
                    mode      = SCAN_START;
                end
                else begin
                    lex_size = bump(lex_size, COUNT_MAX);
                end
            end
            default:
            begin
                mode = SCAN_START;
            end
        endcase

        pos = bump(pos, OFFSET_MAX);
        if (run_count > 0) begin
            tok      = due_tokens.pop_back();
            tok.last = 1'b1;
            due_tokens.push_back(tok);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        token_t got;
        token_t want;
        if (!rst_n) begin
            mode          = SCAN_START;
            pos           = 0;
            lex_begin     = 0;
            lex_size      = 0;
            line_cnt      = 1;
            col_cnt       = 1;
            pend_qual     = QUAL_NONE;
            word_bytes    = '0;
            word_too_long = 1'b0;
            for (int i = 0; i < KEY_REGS; i++)
                key_reg[i] = '0;
            due_tokens.delete();
            errors = 0;
            mismatch_count <= 0;
            tokens_due     <= 0;
        end
        else begin
            // Compare first: a token taken now comes from an earlier byte
            if (token_valid && !token_stall) begin
                got.kind      = token_kind_t'(token_kind);
                got.start     = lexeme_start;
                got.length    = lexeme_length;
                got.line      = line_number;
                got.column    = column_number;
                got.qualifier = qual_t'(qualifier);
                got.last      = last_of_run;
                if (due_tokens.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: unexpected token: %s", $time, describe(got));
                    errors++;
                end
                else begin
                    want = due_tokens.pop_front();
                    if (got !== want) begin
                        if (errors < 10)
                            $display("%0t: token mismatch\n  want %s\n  got  %s",
                                     $time, describe(want), describe(got));
                        errors++;
                    end
                end
            end

            if (cfg_wr_en && cfg_index < KEY_SLOTS)
                key_reg[cfg_index] = cfg_data;

            if (text_valid && !text_stall)
                scan_byte(text_byte);

            mismatch_count <= errors;
            tokens_due     <= due_tokens.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import ctt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 480;

    localparam logic [CFG_INDEX_BITS-1:0] REG_KEYWORD_ZERO  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KEYWORD_ONE   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KEYWORD_TWO   = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KEYWORD_THREE = 2'd3;

    logic                      clk;
    logic                      rst_n       = 1'b0;
    logic                      cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data    = '0;
    logic                      text_valid  = 1'b0;
    logic                      text_stall;
    logic [7:0]                text_byte   = '0;
    logic                      token_valid;
    logic                      token_stall = 1'b0;
    logic [KIND_BITS-1:0]      token_kind;
    logic [START_BITS-1:0]     lexeme_start;
    logic [LENGTH_BITS-1:0]    lexeme_length;
    logic [LINE_BITS-1:0]      line_number;
    logic [COLUMN_BITS-1:0]    column_number;
    logic [QUAL_BITS-1:0]      qualifier;
    logic                      last_of_run;

    int mismatch_count;
    int tokens_due;

    // Traffic knobs shared between the stimulus and the token sink
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    // Text still to be sent, and the words currently loaded as keywords
    logic [7:0] text_q [$];
    string      kw_text [KEY_REGS];

    config_text_tokenizer_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .text_valid    (text_valid),
        .text_stall    (text_stall),
        .text_byte     (text_byte),
        .token_valid   (token_valid),
        .token_stall   (token_stall),
        .token_kind    (token_kind),
        .lexeme_start  (lexeme_start),
        .lexeme_length (lexeme_length),
        .line_number   (line_number),
        .column_number (column_number),
        .qualifier     (qualifier),
        .last_of_run   (last_of_run)
    );

    // Watch both channels, predict every token and count mismatches
    ctt_token_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .text_valid     (text_valid),
        .text_stall     (text_stall),
        .text_byte      (text_byte),
        .token_valid    (token_valid),
        .token_stall    (token_stall),
        .token_kind     (token_kind),
        .lexeme_start   (lexeme_start),
        .lexeme_length  (lexeme_length),
        .line_number    (line_number),
        .column_number  (column_number),
        .qualifier      (qualifier),
        .last_of_run    (last_of_run),
        .mismatch_count (mismatch_count),
        .tokens_due     (tokens_due)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Bound the run; a hang anywhere ends up here
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("config_text_tokenizer_unit regression: fail");
        $finish;
    end

    // Token sink: hold off for a counted stretch when asked, else stall at random
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                token_stall <= 1'b1;
                hold_left--;
            end
            else begin
                token_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Pack a word with its first character in the low byte, zero padded
    function automatic logic [63:0] pack_keyword(string s);
        logic [63:0] v;
        int          i;
        v = '0;
        for (i = 0; i < s.len() && i < 8; i++)
            v[8 * i +: 8] = s[i];
        return v;
    endfunction

    // Write one keyword register; hold the enable for exactly one edge
    task automatic write_keyword(input logic [CFG_INDEX_BITS-1:0] idx,
                                 input logic [63:0] value, input string word);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        kw_text[idx] = word;
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] pick_word_start();
        case ($urandom_range(2))
            0:       return 8'($urandom_range(CH_LOWER_LO, CH_LOWER_HI));
            1:       return 8'($urandom_range(CH_UPPER_LO, CH_UPPER_HI));
            default: return CH_UNDER;
        endcase
    endfunction

    function automatic logic [7:0] pick_word_char();
        case ($urandom_range(4))
            0:       return 8'($urandom_range(CH_LOWER_LO, CH_LOWER_HI));
            1:       return 8'($urandom_range(CH_UPPER_LO, CH_UPPER_HI));
            2:       return 8'($urandom_range(CH_DIGIT_LO, CH_DIGIT_HI));
            3:       return CH_UNDER;
            default: return CH_DOT;
        endcase
    endfunction

    // Body text for strings and comments, printable with some newlines; stop never appears
    function automatic logic [7:0] pick_text_char(input logic [7:0] stop);
        logic [7:0] c;
        c = 8'($urandom_range(8'h20, 8'h7E));
        if ($urandom_range(11) == 0)
            c = CH_HASH;
        else if ($urandom_range(15) == 0)
            c = CH_NEWLINE;
        if (c == stop)
            c = CH_UNDER;
        return c;
    endfunction

    // Often end a number or word on a closing bracket, which yields two tokens
    task automatic add_token_end();
        string ends;
        ends = "]})  \n";
        if ($urandom_range(3) != 0)
            text_q.push_back(ends[$urandom_range(5)]);
    endtask

    // Build mostly well-formed text with random content, plus some noise
    task automatic add_random_text(input int target);
        int    sel;
        int    n;
        int    k;
        string picks;
        while (text_q.size() < target) begin
            sel = $urandom_range(99);
            if (sel < 18) begin
                n = $urandom_range(1, 6);
                repeat (n)
                    text_q.push_back(($urandom_range(7) == 0) ? CH_DOT
                                     : 8'($urandom_range(CH_DIGIT_LO, CH_DIGIT_HI)));
                add_token_end();
            end
            else if (sel < 42) begin
                k = $urandom_range(KEY_REGS - 1);
                if (kw_text[k].len() > 0 && $urandom_range(1) == 1) begin
                    add_str(kw_text[k]);
                    // one extra character turns it back into a plain word
                    if ($urandom_range(5) == 0)
                        text_q.push_back(pick_word_char());
                end
                else begin
                    text_q.push_back(pick_word_start());
                    n = ($urandom_range(15) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 5);
                    repeat (n)
                        text_q.push_back(pick_word_char());
                end
                add_token_end();
            end
            else if (sel < 54) begin
                // strings, now and then left open so they swallow what follows
                text_q.push_back(CH_QUOTE);
                n = $urandom_range(0, 8);
                repeat (n)
                    text_q.push_back(pick_text_char(CH_QUOTE));
                if ($urandom_range(11) != 0)
                    text_q.push_back(CH_QUOTE);
            end
            else if (sel < 60) begin
                text_q.push_back(CH_HASH);
                n = $urandom_range(0, 6);
                repeat (n)
                    text_q.push_back(pick_text_char(CH_HASH));
                text_q.push_back(($urandom_range(1) == 0) ? CH_NEWLINE : CH_HASH);
            end
            else if (sel < 74) begin
                picks = "([]{})";
                text_q.push_back(picks[$urandom_range(5)]);
            end
            else if (sel < 82) begin
                picks = "@&:$";
                text_q.push_back(picks[$urandom_range(3)]);
            end
            else if (sel < 94) begin
                picks = " \n\t,";
                text_q.push_back(picks[$urandom_range(3)]);
            end
            else begin
                text_q.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    // Offer every queued byte as a request; drop valid only for an idle gap
    task automatic send_text();
        while (text_q.size() > 0) begin
            while ($urandom_range(99) < send_idle_pct) begin
                text_valid <= 1'b0;
                @(posedge clk);
            end
            text_valid <= 1'b1;
            text_byte  <= text_q.pop_front();
            do
                @(posedge clk);
            while (text_stall);
        end
        text_valid <= 1'b0;
    endtask

    // Wait until every predicted token has been taken, then let the
    // pipeline settle so a byte with no token cannot race a config write
    task automatic drain_tokens();
        do
            @(posedge clk);
        while (tokens_due != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int sink_stall_pct, input bit with_hold);
        send_idle_pct = idle_pct;
        stall_pct     = sink_stall_pct;
        add_random_text(PHASE_BYTES);
        text_q.push_back(CH_NEWLINE);
        // Hold the sink off while the sender keeps going so the queue fills
        if (with_hold)
            hold_left = HOLD_CYCLES;
        send_text();
        drain_tokens();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Keywords: short ones, a full eight-character one
        write_keyword(REG_KEYWORD_ZERO, pack_keyword("true"), "true");
        write_keyword(REG_KEYWORD_ONE, pack_keyword("false"), "false");
        write_keyword(REG_KEYWORD_TWO, pack_keyword("include"), "include");
        write_keyword(REG_KEYWORD_THREE, pack_keyword("a_b.9Zq_"), "a_b.9Zq_");

        // Directed text: every bracket, a lone ')', each qualifier, a number and
        // a keyword and a word each ended by a closing bracket, '#' inside a
        // string, bytes 0x00 and 0xFF, a comment, a number that starts with '.'
        send_idle_pct = 0;
        stall_pct     = 40;
        add_str("([]{} )@7]$true}:x)&\"#\"");
        text_q.push_back(8'hFF);
        text_q.push_back(8'h00);
        add_str("#c\n.5 ");
        send_text();
        drain_tokens();

        // Sender mostly busy, sink mostly stalled
        run_phase(13, 83, 1'b0);

        // All-ones and all-zero registers never match; single-letter keyword
        write_keyword(REG_KEYWORD_ZERO, '1, "");
        write_keyword(REG_KEYWORD_ONE, '0, "");
        write_keyword(REG_KEYWORD_TWO, pack_keyword("on"), "on");
        write_keyword(REG_KEYWORD_THREE, pack_keyword("x"), "x");

        // Sender mostly idle, sink mostly ready
        run_phase(83, 13, 1'b0);

        write_keyword(REG_KEYWORD_ZERO, pack_keyword("off"), "off");
        write_keyword(REG_KEYWORD_ONE, pack_keyword("null"), "null");
        write_keyword(REG_KEYWORD_TWO, '0, "");
        write_keyword(REG_KEYWORD_THREE, pack_keyword("Zz9_.end"), "Zz9_.end");

        // Full rate both ways, with one long sink hold-off
        run_phase(0, 0, 1'b1);

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && tokens_due == 0)
            $display("config_text_tokenizer_unit regression: pass");
        else
            $display("config_text_tokenizer_unit regression: fail");
        $finish;
    end

endmodule
